/* rtl/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
// No dependencies; included inside module bodies that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FFA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("allocator assertion failed");

// Next-cycle implication, checked outside reset.
`define FFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("allocator assertion failed");

// Condition that must never hold outside reset.
`define FFA_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("allocator assertion failed");

`endif

/* rtl/ffa_pkg.sv */
// Constants, status codes and helpers for the first-fit free-list allocator.
// No dependencies.
package ffa_pkg;

    localparam int HEAP_BYTES  = 65536;
    localparam int GRANULE     = 8;
    localparam int TABLE_DEPTH = HEAP_BYTES / GRANULE;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int GRAN_W      = $clog2(GRANULE);

    localparam int ADDR_W  = 16;
    localparam int SIZE_W  = 18;   // signed size word in the table
    localparam int RSIZE_W = 17;   // rounded request size
    localparam int TOP_W   = 17;
    localparam int HEAP_W  = 17;
    localparam int STAT_W  = 2;

    localparam logic [HEAP_W-1:0] HEAP_RESET = HEAP_W'(65536);
    localparam logic [TOP_W-1:0]  TOP_RESET  = TOP_W'(GRANULE);
    localparam logic [TOP_W-1:0]  TOP_MAX    = {TOP_W{1'b1}};
    localparam logic [SIZE_W-1:0] SIZE_SENT  = {SIZE_W{1'b1}};

    // Result status codes
    localparam logic [STAT_W-1:0] ST_FRESH  = 2'd0;
    localparam logic [STAT_W-1:0] ST_REUSED = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOROOM = 2'd2;
    localparam logic [STAT_W-1:0] ST_FREED  = 2'd3;

    // Request kinds carried on tuser
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [SIZE_W-1:0]  size_word_t;

    // Round a byte count up to a whole number of granules
    function automatic logic [RSIZE_W-1:0] round_up(input logic [ADDR_W-1:0] req);
        logic [RSIZE_W-1:0] sum;
        begin
            sum = RSIZE_W'(req) + RSIZE_W'(GRANULE - 1);
            round_up = {sum[RSIZE_W-1:GRAN_W], {GRAN_W{1'b0}}};
        end
    endfunction

    // Table index of a byte offset
    function automatic idx_t addr_idx(input addr_t a);
        addr_idx = a[GRAN_W +: IDX_W];
    endfunction

endpackage

/* rtl/first_fit_free_list_allocator.sv */
// First-fit free-list heap allocator: block size and next-link tables in
// synchronous RAM, driven by a small read-evaluate-write sequencer.
// Depends on ffa_pkg and assert_macros.svh.
//
// Usage:
//   Requests arrive on the s_ channel: s_tuser is the kind (0 allocate,
//   1 free), s_tdata carries req_size and block_addr. Every request yields
//   exactly one word on the m_ channel with a status and a granted address.
//   User writes heap_size on cfg_ channel only while the block is idle; unchecked.
// Sequence, acceptance to result register:
//   a free or a failed room check goes straight to the output state;
//   else the list head and then each entry behind it is read and
//   evaluated. A hit at the head or a carve goes to the output state; a
//   hit behind the head first clears its link in the unlink state. A
//   cyclic list ends after 8192 entries behind the head with a no-room
//   answer. One request is in flight; the next is taken in the cycle
//   after the result register loads, even while that result still waits.
// Reset:
//   Synchronous, active low: list head to the sentinel, top to 8, heap_size
//   to 65536. No clearing pass; the sentinel reads as size -1, link 0.
// Stall:
//   While m_tready is low the result holds; a finished next result waits in
//   the sequencer and s_tready stays low.
module first_fit_free_list_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] req_size, [31:16] block_addr
    input  logic [0:0]  s_tuser,   // [0] req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] status, [17:2] granted_addr, [23:18] zero
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ffa_pkg::HEAP_W-1:0] cfg_data
);
    import ffa_pkg::*;

    `include "assert_macros.svh"

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_UNLINK = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    localparam logic [IDX_W-1:0] STEP_LAST = {IDX_W{1'b1}};

    // control and datapath registers
    logic [2:0]         state_reg, state_next;
    logic [RSIZE_W-1:0] sz_reg, sz_next;
    addr_t              rd_addr_reg, rd_addr_next;
    addr_t              cur_reg, cur_next;
    logic               first_reg, first_next;
    logic [IDX_W-1:0]   steps_reg, steps_next;
    addr_t              free_head_reg, free_head_next;
    logic [TOP_W-1:0]   top_reg, top_next;
    logic [HEAP_W-1:0]  heap_size_reg;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    addr_t              res_addr_reg, res_addr_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [23:0]        m_tdata_reg, m_tdata_next;
    logic               size0_wr_reg, link0_wr_reg;

    // table memories
    size_word_t size_mem [TABLE_DEPTH];
    addr_t      link_mem [TABLE_DEPTH];
    size_word_t size_rd_reg;
    addr_t      link_rd_reg;
    logic       rd_sent_reg;

    logic       rd_en;
    idx_t       rd_idx;
    logic       size_we, link_we;
    idx_t       size_widx, link_widx;
    size_word_t size_wdata;
    addr_t      link_wdata;

    logic       accept;
    addr_t      in_addr;
    logic [ADDR_W-1:0] in_size;
    size_word_t size_val;
    addr_t      link_val;
    logic       fits, is_sent, room_fail;
    logic [TOP_W:0] top_sum;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign in_size   = s_tdata[15:0];
    assign in_addr   = s_tdata[31:16];

    // sentinel entry reads as -1 / 0 until written
    assign size_val = (rd_sent_reg && !size0_wr_reg) ? SIZE_SENT : size_rd_reg;
    assign link_val = (rd_sent_reg && !link0_wr_reg) ? '0 : link_rd_reg;
    assign fits     = $signed(size_val) >= $signed({1'b0, sz_reg});
    assign is_sent  = (size_val == SIZE_SENT);

    // room check on the rounded size
    assign room_fail = (({1'b0, sz_reg} + (RSIZE_W+1)'(GRANULE)) > {1'b0, heap_size_reg})
                    || ({1'b0, heap_size_reg} < ({1'b0, sz_reg} + {1'b0, top_reg}));
    assign top_sum   = {1'b0, top_reg} + (TOP_W+1)'(sz_reg) + (TOP_W+1)'(GRANULE);

    // table RAMs, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (size_we) begin
            size_mem[size_widx] <= size_wdata;
        end
        if (rd_en) begin
            size_rd_reg <= size_mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_widx] <= link_wdata;
        end
        if (rd_en) begin
            link_rd_reg <= link_mem[rd_idx];
            rd_sent_reg <= (rd_idx == '0);
        end
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        sz_next         = sz_reg;
        rd_addr_next    = rd_addr_reg;
        cur_next        = cur_reg;
        first_next      = first_reg;
        steps_next      = steps_reg;
        free_head_next  = free_head_reg;
        top_next        = top_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        rd_en           = 1'b0;
        rd_idx          = addr_idx(free_head_reg);
        size_we         = 1'b0;
        size_widx       = addr_idx(top_reg[ADDR_W-1:0]);
        size_wdata      = SIZE_W'(sz_reg);
        link_we         = 1'b0;
        link_widx       = addr_idx(top_reg[ADDR_W-1:0]);
        link_wdata      = '0;

        // drop the output word once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_tuser[0] == REQ_FREE) begin
                        // push onto list head
                        link_we         = 1'b1;
                        link_widx       = addr_idx(in_addr);
                        link_wdata      = free_head_reg;
                        free_head_next  = in_addr;
                        res_status_next = ST_FREED;
                        res_addr_next   = in_addr;
                        state_next      = S_OUT;
                    end else begin
                        sz_next    = round_up(in_size);
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (room_fail) begin
                    res_status_next = ST_NOROOM;
                    res_addr_next   = '0;
                    state_next      = S_OUT;
                end else begin
                    // fetch the list head
                    rd_en        = 1'b1;
                    rd_idx       = addr_idx(free_head_reg);
                    rd_addr_next = free_head_reg;
                    first_next   = 1'b1;
                    steps_next   = '0;
                    state_next   = S_EVAL;
                end
            end
            S_EVAL: begin
                if (fits) begin
                    res_status_next = ST_REUSED;
                    res_addr_next   = rd_addr_reg;
                    if (first_reg) begin
                        free_head_next = link_val;
                        state_next     = S_OUT;
                    end else begin
                        // bypass the taken block
                        link_we    = 1'b1;
                        link_widx  = addr_idx(cur_reg);
                        link_wdata = link_val;
                        state_next = S_UNLINK;
                    end
                end else if (is_sent) begin
                    // carve a fresh block at top
                    if (top_reg[TOP_W-1]) begin
                        res_status_next = ST_NOROOM;
                        res_addr_next   = '0;
                    end else begin
                        size_we         = 1'b1;
                        link_we         = 1'b1;
                        res_status_next = ST_FRESH;
                        res_addr_next   = top_reg[ADDR_W-1:0];
                        top_next        = top_sum[TOP_W] ? TOP_MAX : top_sum[TOP_W-1:0];
                    end
                    state_next = S_OUT;
                end else if (!first_reg && (steps_reg == STEP_LAST)) begin
                    // walk limit: treat as cyclic list
                    res_status_next = ST_NOROOM;
                    res_addr_next   = '0;
                    state_next      = S_OUT;
                end else begin
                    // advance to the next entry
                    rd_en        = 1'b1;
                    rd_idx       = addr_idx(link_val);
                    rd_addr_next = link_val;
                    cur_next     = rd_addr_reg;
                    first_next   = 1'b0;
                    if (!first_reg) begin
                        steps_next = steps_reg + 1'b1;
                    end
                end
            end
            S_UNLINK: begin
                // clear the link of the taken block
                link_we    = 1'b1;
                link_widx  = addr_idx(rd_addr_reg);
                link_wdata = '0;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, res_addr_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            top_reg       <= TOP_RESET;
            heap_size_reg <= HEAP_RESET;
            m_tvalid_reg  <= 1'b0;
            size0_wr_reg  <= 1'b0;
            link0_wr_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            top_reg       <= top_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                heap_size_reg <= cfg_data;
            end
            if (size_we && (size_widx == '0)) begin
                size0_wr_reg <= 1'b1;
            end
            if (link_we && (link_widx == '0)) begin
                link0_wr_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        sz_reg         <= sz_next;
        rd_addr_reg    <= rd_addr_next;
        cur_reg        <= cur_next;
        first_reg      <= first_next;
        steps_reg      <= steps_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // a free puts its block at the list head
    `FFA_ASSERT_NEXT(a_free_head, accept && (s_tuser[0] == REQ_FREE), free_head_reg == $past(in_addr))
    // top only moves upward between resets
    `FFA_ASSERT_IMPL(a_top_mono, $past(aresetn), top_reg >= $past(top_reg))
    // a new output word only comes from the output state
    `FFA_ASSERT_IMPL(a_out_src, $rose(m_tvalid_reg), $past(state_reg) == S_OUT)
    // table reads never share a cycle with table writes
    `FFA_ASSERT_NEVER(a_rw_excl, rd_en && (size_we || link_we))

endmodule

/* sim/ffa_grant_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the first-fit free-list allocator: mirrors heap_size, both block
// tables, the list head and the top offset, predicts every result word and compares.
// Depends on ffa_pkg.
module ffa_grant_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [31:0]                s_tdata,   // [15:0] req_size, [31:16] block_addr
    input  logic [0:0]                 s_tuser,   // [0] req_type
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [23:0]                m_tdata,   // [1:0] status, [17:2] granted_addr
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [ffa_pkg::HEAP_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         grants_owed
);
    import ffa_pkg::*;

    localparam logic [TOP_W-1:0] LAST_OFFSET = TOP_W'(16'hFFFF);

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] addr;
    } grant_t;

    grant_t            grant_queue[$];
    logic [SIZE_W-1:0] size_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0] link_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0] list_head;
    logic [TOP_W-1:0]  top_mark;
    logic [HEAP_W-1:0] heap_limit;

    function automatic logic [IDX_W-1:0] slot(input logic [ADDR_W-1:0] a);
        return a[ADDR_W-1:GRAN_W];
    endfunction

    // Size words are signed; the sentinel reads as -1
    function automatic int size_of(input logic [ADDR_W-1:0] a);
        logic signed [SIZE_W-1:0] w;
        w = size_mem[slot(a)];
        return w;
    endfunction

    task automatic report_mismatch(input string field, input int want, input int got);
        $display("%0t ns: %s expected %0d (0x%0h), got %0d (0x%0h)",
                 $time, field, want, want, got, got);
        mismatches++;
    endtask

    // Carve a fresh block at top, refusing once top leaves the addressable range
    task automatic carve_top(input int sz, output logic [STAT_W-1:0] st,
                             output logic [ADDR_W-1:0] ga);
        int nt;
        if (top_mark > LAST_OFFSET) begin
            st = ST_NOROOM;
            ga = '0;
        end else begin
            size_mem[slot(top_mark[ADDR_W-1:0])] = SIZE_W'(sz);
            link_mem[slot(top_mark[ADDR_W-1:0])] = '0;
            ga = top_mark[ADDR_W-1:0];
            nt = int'(top_mark) + sz + GRANULE;
            top_mark = (nt > int'(TOP_MAX)) ? TOP_MAX : TOP_W'(nt);
            st = ST_FRESH;
        end
    endtask

    // Apply one request to the mirrored heap and queue the word it must produce
    task automatic predict_grant(input logic kind, input logic [ADDR_W-1:0] req,
                                 input logic [ADDR_W-1:0] baddr);
        int                sz;
        int                hs;
        int                s;
        int                steps;
        logic              done;
        logic [ADDR_W-1:0] cur;
        logic [ADDR_W-1:0] nxt;
        logic [STAT_W-1:0] st;
        logic [ADDR_W-1:0] ga;
        grant_t            g;
        st = ST_NOROOM;
        ga = '0;
        if (kind == REQ_FREE) begin
            // push on the head, no checks, no merging
            link_mem[slot(baddr)] = list_head;
            list_head = baddr;
            st = ST_FREED;
            ga = baddr;
        end else begin
            sz = (int'(req) + GRANULE - 1) / GRANULE * GRANULE;
            hs = int'(heap_limit);
            if (sz + GRANULE <= hs && hs - sz >= int'(top_mark)) begin
                s = size_of(list_head);
                if (s >= sz) begin
                    st = ST_REUSED;
                    ga = list_head;
                    list_head = link_mem[slot(list_head)];
                end else if (s == -1) begin
                    carve_top(sz, st, ga);
                end else begin
                    // walk behind the head; a circular list gives up after a full table
                    cur = list_head;
                    steps = 0;
                    done = 1'b0;
                    while (!done && steps < TABLE_DEPTH) begin
                        nxt = link_mem[slot(cur)];
                        s = size_of(nxt);
                        if (s >= sz) begin
                            link_mem[slot(cur)] = link_mem[slot(nxt)];
                            link_mem[slot(nxt)] = '0;
                            st = ST_REUSED;
                            ga = nxt;
                            done = 1'b1;
                        end else if (s == -1) begin
                            carve_top(sz, st, ga);
                            done = 1'b1;
                        end else begin
                            cur = nxt;
                            steps++;
                        end
                    end
                end
            end
        end
        g.status = st;
        g.addr = ga;
        grant_queue.push_back(g);
    endtask

    // Track config, requests and result words at each edge
    always @(posedge aclk) begin
        grant_t got;
        grant_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                size_mem[i] = '0;
                link_mem[i] = '0;
            end
            size_mem[0] = SIZE_SENT;
            list_head = '0;
            top_mark = TOP_RESET;
            heap_limit = HEAP_RESET;
            grant_queue.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                heap_limit = cfg_data;
            if (s_tvalid && s_tready)
                predict_grant(s_tuser[0], s_tdata[15:0], s_tdata[31:16]);
            if (m_tvalid && m_tready) begin
                got.status = m_tdata[1:0];
                got.addr = m_tdata[17:2];
                if (grant_queue.size() == 0) begin
                    $display("%0t ns: result word with nothing expected, status %0d addr 0x%04h",
                             $time, got.status, got.addr);
                    mismatches++;
                end else begin
                    want = grant_queue.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", want.status, got.status);
                    if (got.addr !== want.addr)
                        report_mismatch("granted_addr", want.addr, got.addr);
                end
            end
        end
        grants_owed = grant_queue.size();
    end

endmodule

/* sim/tb_first_fit_free_list_allocator.sv */
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, request and config stimulus, result
// stalls and the verdict. Depends on ffa_pkg, the allocator and ffa_grant_checker.
module tb_first_fit_free_list_allocator;
    import ffa_pkg::*;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [31:0]       s_tdata;   // [15:0] req_size, [31:16] block_addr
    logic [0:0]        s_tuser;   // [0] req_type
    logic              m_tvalid;
    logic              m_tready;
    logic [23:0]       m_tdata;   // [1:0] status, [17:2] granted_addr, [23:18] zero
    logic              cfg_valid;
    logic              cfg_ready;
    logic [HEAP_W-1:0] cfg_data;

    int                mismatches;
    int                grants_owed;
    int                words_sent;
    int                words_back;
    int                src_gap_pct;
    int                dst_gap_pct;
    logic              hold_rx;
    logic [STAT_W-1:0] last_status;
    logic [ADDR_W-1:0] last_grant;
    logic [ADDR_W-1:0] live_blocks[$];

    first_fit_free_list_allocator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ffa_grant_checker grant_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .grants_owed (grants_owed)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Stall the result side at random, or hard while a hold is on
    always @(posedge aclk) begin
        m_tready <= !hold_rx && ($urandom_range(99) >= dst_gap_pct);
    end

    // Count returned words and keep the blocks currently handed out
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            words_back <= words_back + 1;
            last_status <= m_tdata[1:0];
            last_grant <= m_tdata[17:2];
            if (m_tdata[1:0] == ST_FRESH || m_tdata[1:0] == ST_REUSED)
                live_blocks.push_back(m_tdata[17:2]);
        end
    end

    // Forget every handed-out block that shares a table slot with a freed address
    function automatic void drop_live(input logic [ADDR_W-1:0] a);
        for (int i = live_blocks.size() - 1; i >= 0; i--)
            if (live_blocks[i][ADDR_W-1:GRAN_W] == a[ADDR_W-1:GRAN_W])
                live_blocks.delete(i);
    endfunction

    // Offer one request word, with random gaps ahead of it, and hold until taken
    task automatic send_word(input logic kind, input logic [ADDR_W-1:0] nbytes,
                             input logic [ADDR_W-1:0] baddr);
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {baddr, nbytes};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (kind == REQ_FREE)
            drop_live(baddr);
    endtask

    // Drop valid and wait until every request has its word back
    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (words_back != words_sent);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic ask(input logic kind, input logic [ADDR_W-1:0] nbytes,
                       input logic [ADDR_W-1:0] baddr);
        send_word(kind, nbytes, baddr);
        drain(0);
    endtask

    task automatic set_heap(input logic [HEAP_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly small allocations and frees of live blocks, some odd addresses
    task automatic random_word();
        int                pick;
        int                r;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] n;
        pick = $urandom_range(99);
        if (pick < 45 && live_blocks.size() > 0) begin
            a = live_blocks[$urandom_range(live_blocks.size() - 1)];
            if ($urandom_range(99) < 15)
                a[GRAN_W-1:0] = GRAN_W'($urandom_range(GRANULE - 1));
            send_word(REQ_FREE, 16'($urandom), a);
        end else if (pick >= 45 && pick < 48) begin
            send_word(REQ_FREE, 16'($urandom), 16'($urandom_range(GRANULE - 1)));
        end else begin
            r = $urandom_range(99);
            if (r < 70)
                n = 16'($urandom_range(127));
            else if (r < 90)
                n = 16'($urandom_range(1023, 128));
            else
                n = 16'($urandom);
            send_word(REQ_ALLOC, n, 16'($urandom));
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] held;
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        hold_rx = 1'b0;
        src_gap_pct = 36;
        dst_gap_pct = 69;
        words_sent = 0;
        words_back = 0;
        last_status = '0;
        last_grant = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: carving, room check, head hit, walk hit, sentinel and odd frees
        ask(REQ_ALLOC, 16'd0, 16'hFFFF);
        ask(REQ_ALLOC, 16'd1, 16'd0);
        ask(REQ_ALLOC, 16'd100, 16'd0);
        ask(REQ_ALLOC, 16'hFFFF, 16'd0);       // size plus header beyond heap
        ask(REQ_ALLOC, 16'd65528, 16'd0);      // fits heap, not above top
        ask(REQ_FREE, 16'hFFFF, 16'd32);
        ask(REQ_ALLOC, 16'd50, 16'd0);         // head fits
        ask(REQ_FREE, 16'd0, 16'd16);
        ask(REQ_FREE, 16'd0, 16'd8);
        ask(REQ_ALLOC, 16'd8, 16'd0);          // walk past a too-small head
        ask(REQ_FREE, 16'd0, 16'd0);           // sentinel goes on the list
        ask(REQ_ALLOC, 16'd4, 16'd0);
        ask(REQ_FREE, 16'd0, 16'd35);          // unaligned address of a live block
        ask(REQ_ALLOC, 16'd100, 16'd0);
        ask(REQ_FREE, 16'd0, 16'd8);
        ask(REQ_ALLOC, 16'd16, 16'd0);         // walk ends at sentinel, carve

        // Smallest heap: allocations all refused
        drain(8);
        set_heap(HEAP_W'(16));
        repeat (6) random_word();

        drain(8);
        set_heap(HEAP_W'(65536));
        src_gap_pct = 36;
        dst_gap_pct <= 69;
        repeat (200) random_word();

        drain(8);
        set_heap(HEAP_W'($urandom_range(65535, 32768)));
        src_gap_pct = 69;
        dst_gap_pct <= 36;
        repeat (200) random_word();

        // Full rate, with a long result stall that backs up the request side
        drain(8);
        set_heap(HEAP_W'(65536));
        src_gap_pct = 0;
        dst_gap_pct <= 0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (300) @(posedge aclk);
                hold_rx <= 1'b0;
            end
            repeat (40) random_word();
        join
        repeat (160) random_word();

        // Circular list from a double free, then run top to the end of the space
        drain(8);
        ask(REQ_FREE, 16'd0, 16'd0);
        ask(REQ_ALLOC, 16'd8, 16'($urandom));
        if (last_status == ST_FRESH) begin
            held = last_grant;
            ask(REQ_FREE, 16'd0, held);
            ask(REQ_FREE, 16'd0, held);
            ask(REQ_ALLOC, 16'd16, 16'd0);     // walk circles, gives up
            ask(REQ_ALLOC, 16'd8, 16'd0);
            ask(REQ_FREE, 16'd0, 16'd0);
        end
        ask(REQ_ALLOC, 16'd0, 16'd0);
        if (last_status == ST_FRESH && last_grant <= 16'd65520) begin
            ask(REQ_ALLOC, 16'd65520 - last_grant, 16'd0);
            ask(REQ_ALLOC, 16'd0, 16'd0);      // top now past the last offset
        end

        drain(16);
        if (mismatches == 0 && grants_owed == 0)
            $display("tb_first_fit_free_list_allocator: done, clean");
        else
            $display("tb_first_fit_free_list_allocator: done, errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_first_fit_free_list_allocator: done, errors");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/ffa_pkg.sv
rtl/first_fit_free_list_allocator.sv
sim/ffa_grant_checker.sv
sim/tb_first_fit_free_list_allocator.sv
